>>> hw/rtl/svgpa_pkg.sv
// Shared types, codes and saturating arithmetic for the SVG path absolutizer.
// No dependencies; every other file of the block imports this package.
package svgpa_pkg;

    // Internal coordinate width (signed Q16.16 at 32 bits)
    localparam int CW      = 32;
    // Width of the coordinate fields at the ports
    localparam int FIELD_W = 32;

    typedef logic signed [CW-1:0]      t_coord;
    typedef logic signed [FIELD_W-1:0] t_field;

    // Input action codes
    typedef logic [2:0] t_action;
    localparam t_action ACT_MOVE   = 3'd0;
    localparam t_action ACT_LINE   = 3'd1;
    localparam t_action ACT_VERT   = 3'd2;
    localparam t_action ACT_HORIZ  = 3'd3;
    localparam t_action ACT_CUBIC  = 3'd4;
    localparam t_action ACT_SMOOTH = 3'd5;
    localparam t_action ACT_CLOSE  = 3'd6;

    // Output segment kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_MOVE  = 2'd0;
    localparam t_kind KIND_LINE  = 2'd1;
    localparam t_kind KIND_CUBIC = 2'd2;
    localparam t_kind KIND_CLOSE = 2'd3;

    // Clamp bounds, held at 65 bits so any width up to 64 fits
    localparam logic signed [64:0] CMAX = (65'sd1 <<< (CW - 1)) - 65'sd1;
    localparam logic signed [64:0] CMIN = -CMAX - 65'sd1;
    localparam logic signed [64:0] FMAX = (65'sd1 <<< (FIELD_W - 1)) - 65'sd1;
    localparam logic signed [64:0] FMIN = -FMAX - 65'sd1;

    typedef struct packed {
        t_action action;
        logic    relative;
        logic    first_of_group;
        t_field  end_x;
        t_field  end_y;
        t_field  first_ctl_x;
        t_field  first_ctl_y;
        t_field  second_ctl_x;
        t_field  second_ctl_y;
    } t_cmd;

    typedef struct packed {
        t_kind  segment_kind;
        t_field out_end_x;
        t_field out_end_y;
        t_field out_ctl1_x;
        t_field out_ctl1_y;
        t_field out_ctl2_x;
        t_field out_ctl2_y;
    } t_seg;

    typedef struct packed {
        t_coord cur_x;
        t_coord cur_y;
        t_coord ctl_x;
        t_coord ctl_y;
        t_coord start_x;
        t_coord start_y;
    } t_state;

    // Saturating add over the internal width
    function automatic t_coord sat_add(input t_coord a, input t_coord b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        if (s[CW] != s[CW-1]) begin
            sat_add = s[CW] ? CMIN[CW-1:0] : CMAX[CW-1:0];
        end else begin
            sat_add = s[CW-1:0];
        end
    endfunction

    // Saturating subtract over the internal width
    function automatic t_coord sat_sub(input t_coord a, input t_coord b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} - {b[CW-1], b};
        if (s[CW] != s[CW-1]) begin
            sat_sub = s[CW] ? CMIN[CW-1:0] : CMAX[CW-1:0];
        end else begin
            sat_sub = s[CW-1:0];
        end
    endfunction

    // Port field into the internal range
    function automatic t_coord coord_in(input t_field v);
        logic signed [64:0] w;
        w = 65'(v);
        if (w > CMAX) begin
            w = CMAX;
        end else if (w < CMIN) begin
            w = CMIN;
        end
        coord_in = w[CW-1:0];
    endfunction

    // Internal coordinate onto the port field range
    function automatic t_field coord_out(input t_coord v);
        logic signed [64:0] w;
        w = 65'(v);
        if (w > FMAX) begin
            w = FMAX;
        end else if (w < FMIN) begin
            w = FMIN;
        end
        coord_out = w[FIELD_W-1:0];
    endfunction

    // Absolute coordinate from a raw field, offset from base when relative
    function automatic t_coord place(input logic rel, input t_coord base, input t_field raw);
        t_coord v;
        v = coord_in(raw);
        place = rel ? sat_add(base, v) : v;
    endfunction

endpackage

>>> hw/rtl/svgpa_cmd_if.sv
// Command channel: valid/ready handshake carrying one path coordinate group.
// Depends on svgpa_pkg.
interface svgpa_cmd_if;
    import svgpa_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    logic    relative;
    logic    first_of_group;
    t_field  end_x;
    t_field  end_y;
    t_field  first_ctl_x;
    t_field  first_ctl_y;
    t_field  second_ctl_x;
    t_field  second_ctl_y;

    modport source (
        output valid, action, relative, first_of_group, end_x, end_y,
               first_ctl_x, first_ctl_y, second_ctl_x, second_ctl_y,
        input  ready
    );

    modport sink (
        input  valid, action, relative, first_of_group, end_x, end_y,
               first_ctl_x, first_ctl_y, second_ctl_x, second_ctl_y,
        output ready
    );
endinterface

>>> hw/rtl/svgpa_seg_if.sv
// Segment channel: valid/ready handshake carrying one absolute segment.
// Depends on svgpa_pkg.
interface svgpa_seg_if;
    import svgpa_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  segment_kind;
    t_field out_end_x;
    t_field out_end_y;
    t_field out_ctl1_x;
    t_field out_ctl1_y;
    t_field out_ctl2_x;
    t_field out_ctl2_y;

    modport source (
        output valid, segment_kind, out_end_x, out_end_y,
               out_ctl1_x, out_ctl1_y, out_ctl2_x, out_ctl2_y,
        input  ready
    );

    modport sink (
        input  valid, segment_kind, out_end_x, out_end_y,
               out_ctl1_x, out_ctl1_y, out_ctl2_x, out_ctl2_y,
        output ready
    );
endinterface

>>> hw/rtl/svgpa_calc.sv
// Combinational datapath: one command group plus the path state in,
// one absolute segment and the next path state out. Depends on svgpa_pkg.
module svgpa_calc (
    input  svgpa_pkg::t_cmd   i_cmd,
    input  svgpa_pkg::t_state i_state,
    output svgpa_pkg::t_seg   o_seg,
    output logic              o_has_seg,
    output svgpa_pkg::t_state o_state
);
    import svgpa_pkg::*;

    t_coord ex, ey, c1x, c1y, c2x, c2y;
    t_coord refl_x, refl_y;
    t_kind  kind;

    // Offset from the last control point to the current point; added to the current point it gives the reflection
    assign refl_x = sat_sub(i_state.cur_x, i_state.ctl_x);
    assign refl_y = sat_sub(i_state.cur_y, i_state.ctl_y);

    always_comb begin
        o_state   = i_state;
        o_has_seg = 1'b1;
        kind      = KIND_LINE;
        ex        = i_state.cur_x;
        ey        = i_state.cur_y;
        c1x       = '0;
        c1y       = '0;
        c2x       = '0;
        c2y       = '0;

        unique case (i_cmd.action)
            ACT_MOVE, ACT_LINE: begin
                ex = place(i_cmd.relative, i_state.cur_x, i_cmd.end_x);
                ey = place(i_cmd.relative, i_state.cur_y, i_cmd.end_y);
                // first pair of a move opens a new subpath
                if (i_cmd.action == ACT_MOVE && i_cmd.first_of_group) begin
                    kind            = KIND_MOVE;
                    o_state.start_x = ex;
                    o_state.start_y = ey;
                end
                o_state.ctl_x = ex;
                o_state.ctl_y = ey;
            end
            ACT_VERT: begin
                ey            = place(i_cmd.relative, i_state.cur_y, i_cmd.end_y);
                o_state.ctl_x = ex;
                o_state.ctl_y = ey;
            end
            ACT_HORIZ: begin
                ex            = place(i_cmd.relative, i_state.cur_x, i_cmd.end_x);
                o_state.ctl_x = ex;
                o_state.ctl_y = ey;
            end
            ACT_CUBIC, ACT_SMOOTH: begin
                if (i_cmd.action == ACT_CUBIC) begin
                    c1x = place(i_cmd.relative, i_state.cur_x, i_cmd.first_ctl_x);
                    c1y = place(i_cmd.relative, i_state.cur_y, i_cmd.first_ctl_y);
                end else begin
                    c1x = sat_add(i_state.cur_x, refl_x);
                    c1y = sat_add(i_state.cur_y, refl_y);
                end
                c2x           = place(i_cmd.relative, i_state.cur_x, i_cmd.second_ctl_x);
                c2y           = place(i_cmd.relative, i_state.cur_y, i_cmd.second_ctl_y);
                ex            = place(i_cmd.relative, i_state.cur_x, i_cmd.end_x);
                ey            = place(i_cmd.relative, i_state.cur_y, i_cmd.end_y);
                kind          = KIND_CUBIC;
                o_state.ctl_x = c2x;
                o_state.ctl_y = c2y;
            end
            ACT_CLOSE: begin
                ex            = i_state.start_x;
                ey            = i_state.start_y;
                kind          = KIND_CLOSE;
                o_state.ctl_x = ex;
                o_state.ctl_y = ey;
            end
            default: begin
                // unused code: no segment, state untouched
                o_has_seg = 1'b0;
            end
        endcase

        if (o_has_seg) begin
            o_state.cur_x = ex;
            o_state.cur_y = ey;
        end
    end

    // Result item
    always_comb begin
        o_seg.segment_kind = kind;
        o_seg.out_end_x    = coord_out(ex);
        o_seg.out_end_y    = coord_out(ey);
        o_seg.out_ctl1_x   = coord_out(c1x);
        o_seg.out_ctl1_y   = coord_out(c1y);
        o_seg.out_ctl2_x   = coord_out(c2x);
        o_seg.out_ctl2_y   = coord_out(c2y);
    end

endmodule

>>> hw/rtl/svg_path_absolutizer.sv
// SVG path absolutizer top level: input register, datapath, result register.
// Each command is held in the input register, its segment then in the result register.
// One command per cycle while the segment output is not stalled.
// Reset (synchronous, i_rst_n low): both stages empty, path state at zero.
// Depends on svgpa_pkg, svgpa_cmd_if, svgpa_seg_if and svgpa_calc.
module svg_path_absolutizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svgpa_cmd_if.sink   i_cmd,
    svgpa_seg_if.source o_seg
);
    import svgpa_pkg::*;

    logic   r_in_valid;
    t_cmd   r_in;
    logic   r_out_valid;
    t_seg   r_seg;
    t_state r_state;

    t_seg   n_seg;
    t_state n_state;
    logic   calc_has_seg;
    logic   advance;
    t_cmd   cmd_word;

    // Stage 2 moves when the result register is empty or being drained
    assign advance     = !r_out_valid || o_seg.ready;
    assign i_cmd.ready = !r_in_valid || advance;

    always_comb begin
        cmd_word.action         = i_cmd.action;
        cmd_word.relative       = i_cmd.relative;
        cmd_word.first_of_group = i_cmd.first_of_group;
        cmd_word.end_x          = i_cmd.end_x;
        cmd_word.end_y          = i_cmd.end_y;
        cmd_word.first_ctl_x    = i_cmd.first_ctl_x;
        cmd_word.first_ctl_y    = i_cmd.first_ctl_y;
        cmd_word.second_ctl_x   = i_cmd.second_ctl_x;
        cmd_word.second_ctl_y   = i_cmd.second_ctl_y;
    end

    svgpa_calc u_calc (
        .i_cmd     (r_in),
        .i_state   (r_state),
        .o_seg     (n_seg),
        .o_has_seg (calc_has_seg),
        .o_state   (n_state)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= cmd_word;
        end
    end

    // Path state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && calc_has_seg;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && calc_has_seg) begin
            r_seg <= n_seg;
        end
    end

    assign o_seg.valid        = r_out_valid;
    assign o_seg.segment_kind = r_seg.segment_kind;
    assign o_seg.out_end_x    = r_seg.out_end_x;
    assign o_seg.out_end_y    = r_seg.out_end_y;
    assign o_seg.out_ctl1_x   = r_seg.out_ctl1_x;
    assign o_seg.out_ctl1_y   = r_seg.out_ctl1_y;
    assign o_seg.out_ctl2_x   = r_seg.out_ctl2_x;
    assign o_seg.out_ctl2_y   = r_seg.out_ctl2_y;

    // An unused code is dropped without a segment
    a_drop_unused : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && !calc_has_seg) |=> !r_out_valid)
        else $error("unused action produced a segment");

    // A close leaves the current point at the subpath start
    a_close_point : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && r_in.action == ACT_CLOSE) |=>
        (r_state.cur_x == r_state.start_x && r_state.cur_y == r_state.start_y))
        else $error("close did not return to subpath start");

    // Only cubics carry control points
    a_ctl_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_seg.segment_kind != KIND_CUBIC) |->
        (r_seg.out_ctl1_x == '0 && r_seg.out_ctl1_y == '0 &&
         r_seg.out_ctl2_x == '0 && r_seg.out_ctl2_y == '0))
        else $error("non-cubic segment with control points");

    // An empty input stage always takes a command
    a_ready_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_cmd.ready)
        else $error("input stage empty but not ready");

endmodule
